@@ rtl/rset_pkg.sv @@
// Package for the randomized set table: sizes, operation codes and status codes.
// Used by the top level and the testbench; depends on nothing.
`default_nettype none

package rset_pkg;

    localparam int DEPTH    = 64;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int VAL_W    = 32;
    localparam int DRAW_W   = 32;
    localparam int FUNC_W   = 2;
    localparam int STAT_W   = 2;
    localparam int MCOUNT_W = 7;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 48;

    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam func_t FUNC_INSERT = 2'd0;
    localparam func_t FUNC_ERASE  = 2'd1;
    localparam func_t FUNC_SAMPLE = 2'd2;
    localparam func_t FUNC_NONE   = 2'd3;

    localparam status_t STAT_DONE  = 2'd0;
    localparam status_t STAT_MISS  = 2'd1;
    localparam status_t STAT_FULL  = 2'd2;
    localparam status_t STAT_EMPTY = 2'd3;

endpackage

`default_nettype wire

@@ rtl/rset_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the slot values of the randomized set table.
`default_nettype none

module rset_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/randomized_set_table.sv @@
// Top level of the randomized set table: sequencer, sample multiplier and slot RAM.
// Depends on rset_pkg and rset_ram.
//
// Usage:
//   Input channel s_*: s_tuser carries the operation (insert, erase, sample),
//   s_tdata carries the value and the random draw. Each accepted item gives
//   exactly one result item on m_*: status, sampled member and member count.
//   Insert and erase scan the occupied slots one a cycle through the single
//   RAM read port, with a comparator on the registered read data; an erase
//   that hits then reads the last slot and writes it into the hole. Sample
//   steps through the draw * count multiply, the RAM read and the capture of
//   the read data; an unused operation goes straight to the result. Only one
//   item is in work at a time; s_tready is high while the sequencer is idle.
//   The result sits in an output register; a new item is accepted while it
//   waits, and the sequencer holds a finished result until the register frees.
//   Reset empties the set at once (count to zero); slot contents are not
//   cleared, since only occupied slots are ever read.
`default_nettype none

module randomized_set_table (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // [31:0] value, [63:32] rand_draw
    input  wire logic [rset_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] func
    input  wire logic [rset_pkg::FUNC_W-1:0]  s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [1:0] status, [33:2] sample_value, [40:34] member_count, [47:41] zero
    output logic      [rset_pkg::M_DATA_W-1:0] m_tdata
);
    import rset_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ERASE_RD,
        ST_ERASE_WR,
        ST_MUL,
        ST_SMP_RD,
        ST_SMP_CAP,
        ST_RESP
    } state_t;

    localparam int PROD_W = DRAW_W + CNT_W;

    state_t             state_reg, state_next;
    func_t              func_reg, func_next;
    logic [VAL_W-1:0]   value_reg, value_next;
    logic [DRAW_W-1:0]  draw_reg, draw_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    status_t            res_status_reg, res_status_next;
    logic [VAL_W-1:0]   res_sample_reg, res_sample_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [VAL_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [VAL_W-1:0]   ram_rdata;

    logic [CNT_W-1:0]   last_idx;
    logic [PROD_W-1:0]  prod;
    logic               hit;
    logic               out_free;

    rset_ram #(
        .WIDTH(VAL_W),
        .DEPTH(DEPTH)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign last_idx = count_reg - CNT_W'(1);
    assign prod     = PROD_W'(draw_reg) * PROD_W'(count_reg);
    assign hit      = pend_reg && (ram_rdata == value_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        value_next      = value_reg;
        draw_next       = draw_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_sample_next = res_sample_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        ram_waddr       = pend_idx_reg;
        ram_wdata       = value_reg;
        ram_raddr       = issue_reg[ADDR_W-1:0];

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next       = s_tuser;
                    value_next      = s_tdata[VAL_W-1:0];
                    draw_next       = s_tdata[VAL_W +: DRAW_W];
                    issue_next      = '0;
                    pend_next       = 1'b0;
                    res_status_next = STAT_DONE;
                    res_sample_next = '0;
                    unique case (s_tuser)
                        FUNC_INSERT, FUNC_ERASE: state_next = ST_SCAN;
                        FUNC_SAMPLE: begin
                            if (count_reg == '0) begin
                                res_status_next = STAT_EMPTY;
                                state_next      = ST_RESP;
                            end else begin
                                state_next = ST_MUL;
                            end
                        end
                        default: state_next = ST_RESP;
                    endcase
                end
            end

            ST_SCAN: begin
                if (hit) begin
                    // member found: insert misses, erase fills the hole from the last slot
                    pend_next = 1'b0;
                    if (func_reg == FUNC_INSERT) begin
                        res_status_next = STAT_MISS;
                        state_next      = ST_RESP;
                    end else begin
                        pos_next   = pend_idx_reg;
                        state_next = ST_ERASE_RD;
                    end
                end else if (issue_reg < count_reg) begin
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[ADDR_W-1:0];
                    issue_next    = issue_reg + CNT_W'(1);
                end else begin
                    pend_next  = 1'b0;
                    state_next = ST_RESP;
                    if (func_reg == FUNC_ERASE) begin
                        res_status_next = STAT_MISS;
                    end else if (count_reg == CNT_W'(DEPTH)) begin
                        res_status_next = STAT_FULL;
                    end else begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[ADDR_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end

            ST_ERASE_RD: begin
                ram_raddr  = last_idx[ADDR_W-1:0];
                state_next = ST_ERASE_WR;
            end

            ST_ERASE_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = ram_rdata;
                count_next = last_idx;
                state_next = ST_RESP;
            end

            ST_MUL: begin
                pos_next   = prod[DRAW_W +: ADDR_W];
                state_next = ST_SMP_RD;
            end

            ST_SMP_RD: begin
                ram_raddr  = pos_reg;
                state_next = ST_SMP_CAP;
            end

            ST_SMP_CAP: begin
                res_sample_next = ram_rdata;
                state_next      = ST_RESP;
            end

            ST_RESP: begin
                // hold the result until the output register frees
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {
                        (M_DATA_W - STAT_W - VAL_W - MCOUNT_W)'(0),
                        MCOUNT_W'(count_reg),
                        res_sample_reg,
                        res_status_reg
                    };
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        func_reg       <= func_next;
        value_reg      <= value_next;
        draw_reg       <= draw_next;
        issue_reg      <= issue_next;
        pend_idx_reg   <= pend_idx_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_sample_reg <= res_sample_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule

`default_nettype wire

@@ sim/randomized_set_table_tb.sv @@
// Self-checking testbench for randomized_set_table: insert, erase and sample on the member set.
// Keeps its own copy of the set, predicts each result item and compares it field by field.
// Depends on rset_pkg and the RTL of the block.

module randomized_set_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rset_pkg::*;

    typedef struct packed {
        status_t          status;
        logic [VAL_W-1:0] sample;
        logic [6:0]       count;
    } op_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;  // [31:0] value, [63:32] rand_draw
    logic [FUNC_W-1:0]   s_tuser  = '0;  // [1:0] func
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;  // [1:0] status, [33:2] sample_value, [40:34] member_count

    // Own copy of the set: members packed densely in slots 0..member_cnt-1
    logic [VAL_W-1:0] member_vals [DEPTH];
    int unsigned      member_cnt = 0;
    logic [VAL_W-1:0] value_pool [16];

    op_result_t  replies_due [$];
    int unsigned mismatches  = 0;
    bit          no_gaps     = 1'b0;
    int unsigned ready_hold  = 0;

    randomized_set_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("randomized_set_table_tb: errors");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Apply one operation to the member set and return the reply it should give
    function automatic op_result_t apply_set_op(input func_t f, input logic [VAL_W-1:0] v,
                                                input logic [DRAW_W-1:0] draw);
        op_result_t  res;
        int unsigned hit;
        logic [63:0] prod;
        res.status = STAT_DONE;
        res.sample = '0;
        hit = DEPTH;
        for (int unsigned i = 0; i < member_cnt; i++) begin
            if (hit == DEPTH && member_vals[i] == v) hit = i;
        end
        case (f)
            FUNC_INSERT: begin
                if (hit != DEPTH) begin
                    res.status = STAT_MISS;
                end else if (member_cnt >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    member_vals[member_cnt] = v;
                    member_cnt++;
                end
            end
            FUNC_ERASE: begin
                if (hit == DEPTH) begin
                    res.status = STAT_MISS;
                end else begin
                    // fill the hole from the last slot, which may be the hole itself
                    member_vals[hit] = member_vals[member_cnt - 1];
                    member_cnt--;
                end
            end
            FUNC_SAMPLE: begin
                if (member_cnt == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    prod = 64'(draw) * 64'(member_cnt);
                    hit = prod[63:32];
                    if (hit >= member_cnt) hit = member_cnt - 1;
                    res.sample = member_vals[hit];
                end
            end
            default: ;
        endcase
        res.count = 7'(member_cnt);
        return res;
    endfunction

    task automatic send_op(input func_t f, input logic [VAL_W-1:0] v,
                           input logic [DRAW_W-1:0] draw);
        int unsigned pause;
        op_result_t  due;
        pause = no_gaps ? 0 : pick_gap();
        if (pause > 0) begin
            s_tvalid = 1'b0;
            repeat (pause) @(negedge aclk);
        end
        s_tuser  = f;
        s_tdata  = {draw, v};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        due = apply_set_op(f, v, draw);
        replies_due = {replies_due, due};
        @(negedge aclk);
    endtask

    // Hold the sender until every reply is in
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (replies_due.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected %0h, actual %0h", name, want, got);
        end
    endtask

    // Receiver stalls: mostly ready, occasional holds of random length
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_tready   <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 3) == 0) ready_hold <= pick_gap();
        end
    end

    always @(posedge aclk) begin : reply_check
        op_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                mismatches++;
                $error("result item with none expected: m_tdata %h", m_tdata);
            end else begin
                want = replies_due.pop_front();
                check_field("status", VAL_W'(want.status), VAL_W'(m_tdata[1:0]));
                check_field("sample_value", want.sample, m_tdata[33:2]);
                check_field("member_count", VAL_W'(want.count), VAL_W'(m_tdata[40:34]));
                check_field("padding", '0, VAL_W'(m_tdata[47:41]));
            end
        end
    end

    task automatic test_empty_store();
        send_op(FUNC_SAMPLE, $urandom(), $urandom());
        send_op(FUNC_ERASE, 32'h0000_0000, $urandom());
        send_op(FUNC_ERASE, 32'h8000_0000, $urandom());
        send_op(FUNC_NONE, $urandom(), $urandom());
    endtask

    task automatic test_extremes();
        send_op(FUNC_INSERT, 32'h8000_0000, 32'h0);
        send_op(FUNC_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
        send_op(FUNC_INSERT, 32'h0000_0000, $urandom());
        send_op(FUNC_INSERT, 32'hffff_ffff, $urandom());
        send_op(FUNC_INSERT, 32'h7fff_ffff, $urandom());  // already present
        send_op(FUNC_SAMPLE, $urandom(), 32'h0000_0000);
        send_op(FUNC_SAMPLE, $urandom(), 32'hffff_ffff);
        send_op(FUNC_SAMPLE, $urandom(), 32'h8000_0000);
        send_op(FUNC_ERASE, 32'hffff_ffff, $urandom());   // last slot moves onto itself
        send_op(FUNC_ERASE, 32'h8000_0000, $urandom());   // hole filled from the tail
        send_op(FUNC_SAMPLE, $urandom(), 32'h0000_0000);
        send_op(FUNC_ERASE, 32'h1234_5678, $urandom());
        send_op(FUNC_NONE, 32'hffff_ffff, 32'hffff_ffff);
        send_op(FUNC_ERASE, 32'h7fff_ffff, $urandom());
        send_op(FUNC_ERASE, 32'h0000_0000, $urandom());
        send_op(FUNC_SAMPLE, $urandom(), $urandom());
    endtask

    function automatic logic [VAL_W-1:0] pick_operand(input int unsigned member_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < member_pct && member_cnt > 0)
            return member_vals[$urandom_range(0, member_cnt - 1)];
        if (r < member_pct + 15) return value_pool[$urandom_range(0, 15)];
        return $urandom();
    endfunction

    // Alternate fill and drain phases so the set swings between empty and full
    task automatic test_random_mix(input int unsigned n_items);
        int unsigned r;
        int unsigned ins_pct;
        logic [DRAW_W-1:0] draw;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 16; i++) value_pool[i] = $urandom();
        for (int unsigned p = 0; p < 10; p++) begin
            no_gaps = (p % 4 == 3);
            ins_pct = (p % 2 == 0) ? 75 : 15;
            for (int unsigned i = 0; i < n_items / 10; i++) begin
                r = $urandom_range(0, 99);
                draw = $urandom();
                if ($urandom_range(0, 9) == 0) draw = 32'h0;
                else if ($urandom_range(0, 9) == 0) draw = 32'hffff_ffff;
                if (r < ins_pct) send_op(FUNC_INSERT, pick_operand(20), draw);
                else if (r < 90) send_op(FUNC_ERASE, pick_operand(70), draw);
                else if (r < 98) send_op(FUNC_SAMPLE, $urandom(), draw);
                else send_op(FUNC_NONE, $urandom(), draw);
            end
            if (p % 3 == 1) wait_idle();
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_empty_store();
        test_extremes();
        wait_idle();
        test_random_mix(1250);
        s_tvalid = 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (mismatches == 0) begin
            $display("randomized_set_table_tb: clean");
        end else begin
            $display("randomized_set_table_tb: errors");
        end
        $finish;
    end

endmodule
